[sv/vat_pkg.sv]
// Shared types, constants and helpers for the vertex affine transform.
package vat_pkg;

  localparam int CFG_W     = 64;  // widest configuration register
  localparam int IDX_W     = 3;   // register index width (upper codes are ignored)
  localparam int R_W       = 21;  // transformed direction component, Q.14 signed
  localparam int SQ_W      = 40;  // one squared component
  localparam int LEN_W     = 41;  // squared length, units of 2^-28
  localparam int RAD_W     = 61;  // radicand: length shifted left by 20
  localparam int ROOT_W    = 31;  // integer square root of the radicand
  localparam int SQ_STEPS  = 31;  // one root bit per stage
  localparam int NUM_W     = 45;  // dividend: |r| << 24 plus half the root
  localparam int DIV_STEPS = 16;  // one quotient bit per stage
  // squares, length, root, dividend prep, divide, final select
  localparam int DIR_LAT   = 1 + 1 + SQ_STEPS + 1 + DIV_STEPS + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW_X   = 3'd0,
    REG_ROW_Y   = 3'd1,
    REG_ROW_Z   = 3'd2,
    REG_MIN_LEN = 3'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] ROW_X_RST   = 64'h0000_0000_0000_1000;
  localparam logic [CFG_W-1:0] ROW_Y_RST   = 64'h0000_0000_1000_0000;
  localparam logic [CFG_W-1:0] ROW_Z_RST   = 64'h0000_1000_0000_0000;
  localparam logic [15:0]      MIN_LEN_RST = 16'd27;

  localparam logic [15:0] Q14_ONE  = 16'h4000;
  localparam logic [15:0] Q14_ZERO = 16'h0000;

  typedef logic [2:0][15:0]    vec16_t;
  typedef logic [2:0][R_W-1:0] rvec_t;

  // Clamp to signed 16 bits.
  function automatic logic [15:0] sat16(input logic signed [35:0] v);
    logic [15:0] res;
    if (v > 36'sd32767) begin
      res = 16'h7FFF;
    end else if (v < -36'sd32768) begin
      res = 16'h8000;
    end else begin
      res = v[15:0];
    end
    return res;
  endfunction

endpackage

[sv/vertex_affine_transform.sv]
// Top level: vertex position transform plus normal and tangent renormalize.
//
//  channel | ports                       | moves
//  --------+-----------------------------+-------------------------------------
//  in      | in_valid / in_stall         | one vertex per transaction
//  out     | out_valid / out_stall       | one transformed vertex per transaction
//  cfg     | cfg_we, cfg_index, cfg_data | register write, no wait, no read-back
//
// One vertex per clock sustained while the output is not held. The path runs
// through the product and sum registers, then the direction units (squares,
// length, 31-stage root, dividend prep, 16-stage divide, fallback select).
// The pipeline moves as a whole; it holds only when a finished transaction
// sits in the output register and out_stall is high, and in_stall is high
// exactly then. Reset (synchronous, rst_n low) clears the valid bits and
// loads the identity matrix and the default length threshold.
module vertex_affine_transform (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [vat_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vat_pkg::CFG_W-1:0]   cfg_data,
  // input vertex
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [15:0]          in_pos_x,
  input  logic signed [15:0]          in_pos_y,
  input  logic signed [15:0]          in_pos_z,
  input  logic signed [15:0]          in_nrm_x,
  input  logic signed [15:0]          in_nrm_y,
  input  logic signed [15:0]          in_nrm_z,
  input  logic signed [15:0]          in_tan_x,
  input  logic signed [15:0]          in_tan_y,
  input  logic signed [15:0]          in_tan_z,
  input  logic                        in_tan_neg,
  input  logic [15:0]                 in_tex_u,
  input  logic [15:0]                 in_tex_v,
  // output vertex
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [15:0]          out_pos_x,
  output logic signed [15:0]          out_pos_y,
  output logic signed [15:0]          out_pos_z,
  output logic signed [15:0]          out_nrm_x,
  output logic signed [15:0]          out_nrm_y,
  output logic signed [15:0]          out_nrm_z,
  output logic signed [15:0]          out_tan_x,
  output logic signed [15:0]          out_tan_y,
  output logic signed [15:0]          out_tan_z,
  output logic                        out_handed_neg,
  output logic [15:0]                 out_tex_u,
  output logic [15:0]                 out_tex_v
);

  localparam int LAT = vat_pkg::DIR_LAT;

  typedef struct packed {
    logic                valid;
    vat_pkg::vec16_t     pos;
    logic                hand;
    logic [15:0]         tex_u;
    logic [15:0]         tex_v;
  } side_t;

  // ---------------- configuration registers ----------------
  logic [vat_pkg::CFG_W-1:0] row_x_r, row_y_r, row_z_r;
  logic [15:0]               min_len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_x_r   <= vat_pkg::ROW_X_RST;
      row_y_r   <= vat_pkg::ROW_Y_RST;
      row_z_r   <= vat_pkg::ROW_Z_RST;
      min_len_r <= vat_pkg::MIN_LEN_RST;
    end else if (cfg_we) begin
      case (vat_pkg::cfg_reg_t'(cfg_index))
        vat_pkg::REG_ROW_X:   row_x_r   <= cfg_data;
        vat_pkg::REG_ROW_Y:   row_y_r   <= cfg_data;
        vat_pkg::REG_ROW_Z:   row_z_r   <= cfg_data;
        vat_pkg::REG_MIN_LEN: min_len_r <= cfg_data[15:0];
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // m[i][j]: row i, column j; column 3 is the translation
  logic [vat_pkg::CFG_W-1:0] rows [3];
  logic signed [15:0]        m [3][4];

  assign rows[0] = row_x_r;
  assign rows[1] = row_y_r;
  assign rows[2] = row_z_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        m[i][j] = $signed(rows[i][16*j +: 16]);
      end
    end
  end

  // ---------------- pipeline control ----------------
  logic  en;
  side_t line_r [LAT];

  assign en       = !(line_r[LAT-1].valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage 1: products ----------------
  logic signed [15:0] p_in [3], n_in [3], t_in [3];
  logic signed [31:0] pp_r [3][3], np_r [3][3], tp_r [3][3];
  logic               s1_valid_r;
  logic               s1_hand_r;
  logic [15:0]        s1_tex_u_r, s1_tex_v_r;

  assign p_in[0] = in_pos_x;  assign p_in[1] = in_pos_y;  assign p_in[2] = in_pos_z;
  assign n_in[0] = in_nrm_x;  assign n_in[1] = in_nrm_y;  assign n_in[2] = in_nrm_z;
  assign t_in[0] = in_tan_x;  assign t_in[1] = in_tan_y;  assign t_in[2] = in_tan_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pp_r[i][j] <= p_in[j] * m[i][j];
          np_r[i][j] <= n_in[j] * m[i][j];
          tp_r[i][j] <= t_in[j] * m[i][j];
        end
      end
      s1_hand_r  <= in_tan_neg;
      s1_tex_u_r <= in_tex_u;
      s1_tex_v_r <= in_tex_v;
    end
  end

  // ---------------- stage 2: sums, round half up ----------------
  logic signed [34:0] pos_acc [3];
  logic signed [34:0] pos_sh  [3];
  logic signed [33:0] n_acc [3], t_acc [3];
  logic signed [33:0] n_sh  [3], t_sh  [3];
  vat_pkg::vec16_t    pos_nxt;
  vat_pkg::rvec_t     rn_nxt, rt_nxt;
  vat_pkg::rvec_t     rn_r, rt_r;
  side_t              s2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pos_acc[i] = 35'(pp_r[i][0]) + 35'(pp_r[i][1]) + 35'(pp_r[i][2])
                 + (35'(m[i][3]) <<< 12) + 35'sd2048;
      pos_sh[i]  = pos_acc[i] >>> 12;
      pos_nxt[i] = vat_pkg::sat16(36'(pos_sh[i]));
      n_acc[i]   = 34'(np_r[i][0]) + 34'(np_r[i][1]) + 34'(np_r[i][2]) + 34'sd2048;
      t_acc[i]   = 34'(tp_r[i][0]) + 34'(tp_r[i][1]) + 34'(tp_r[i][2]) + 34'sd2048;
      n_sh[i]    = n_acc[i] >>> 12;
      t_sh[i]    = t_acc[i] >>> 12;
      rn_nxt[i]  = n_sh[i][vat_pkg::R_W-1:0];
      rt_nxt[i]  = t_sh[i][vat_pkg::R_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end else if (en) begin
      s2_r.valid <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r.pos   <= pos_nxt;
      s2_r.hand  <= s1_hand_r;
      s2_r.tex_u <= s1_tex_u_r;
      s2_r.tex_v <= s1_tex_v_r;
      rn_r       <= rn_nxt;
      rt_r       <= rt_nxt;
    end
  end

  // ---------------- direction units ----------------
  vat_pkg::vec16_t nrm_fb, tan_fb, nrm_dir, tan_dir;

  assign nrm_fb = {vat_pkg::Q14_ZERO, vat_pkg::Q14_ONE, vat_pkg::Q14_ZERO};
  assign tan_fb = {vat_pkg::Q14_ZERO, vat_pkg::Q14_ZERO, vat_pkg::Q14_ONE};

  vat_dir u_nrm (
    .clk   (clk),
    .en    (en),
    .thr_i (min_len_r),
    .fb_i  (nrm_fb),
    .r_i   (rn_r),
    .dir_o (nrm_dir)
  );

  vat_dir u_tan (
    .clk   (clk),
    .en    (en),
    .thr_i (min_len_r),
    .fb_i  (tan_fb),
    .r_i   (rt_r),
    .dir_o (tan_dir)
  );

  // ---------------- side delay line, last entry is the output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) begin
        line_r[k].valid <= 1'b0;
      end
    end else if (en) begin
      line_r[0] <= s2_r;
      for (int k = 1; k < LAT; k++) begin
        line_r[k] <= line_r[k-1];
      end
    end
  end

  assign out_valid      = line_r[LAT-1].valid;
  assign out_pos_x      = $signed(line_r[LAT-1].pos[0]);
  assign out_pos_y      = $signed(line_r[LAT-1].pos[1]);
  assign out_pos_z      = $signed(line_r[LAT-1].pos[2]);
  assign out_nrm_x      = $signed(nrm_dir[0]);
  assign out_nrm_y      = $signed(nrm_dir[1]);
  assign out_nrm_z      = $signed(nrm_dir[2]);
  assign out_tan_x      = $signed(tan_dir[0]);
  assign out_tan_y      = $signed(tan_dir[1]);
  assign out_tan_z      = $signed(tan_dir[2]);
  assign out_handed_neg = line_r[LAT-1].hand;
  assign out_tex_u      = line_r[LAT-1].tex_u;
  assign out_tex_v      = line_r[LAT-1].tex_v;

endmodule

[sv/vat_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module vat_sqrt #(
  parameter int SIDE_W = 64
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [vat_pkg::RAD_W-1:0]   rad_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic [vat_pkg::ROOT_W-1:0]  root_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int W = vat_pkg::RAD_W + 1;
  localparam int N = vat_pkg::SQ_STEPS;

  logic [W-1:0]      n_r   [N];
  logic [W-1:0]      res_r [N];
  logic [SIDE_W-1:0] side_r[N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int SH = 2 * (N - 1 - k);
    logic [W-1:0]      n_in;
    logic [W-1:0]      res_in;
    logic [W-1:0]      trial;
    logic [SIDE_W-1:0] side_in;

    if (k == 0) begin : g_first
      assign n_in    = W'(rad_i);
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign n_in    = n_r[k-1];
      assign res_in  = res_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = res_in + (W'(1) << SH);

    always_ff @(posedge clk) begin
      if (en) begin
        if (n_in >= trial) begin
          n_r[k]   <= n_in - trial;
          res_r[k] <= (res_in >> 1) + (W'(1) << SH);
        end else begin
          n_r[k]   <= n_in;
          res_r[k] <= res_in >> 1;
        end
        side_r[k] <= side_in;
      end
    end
  end

  assign root_o = res_r[N-1][vat_pkg::ROOT_W-1:0];
  assign side_o = side_r[N-1];

endmodule

[sv/vat_div.sv]
// Pipelined restoring divider, three dividends over one divisor.
module vat_div #(
  parameter int SIDE_W = 4
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic [2:0][vat_pkg::NUM_W-1:0] num_i,
  input  logic [vat_pkg::ROOT_W-1:0]  den_i,
  input  logic [SIDE_W-1:0]           side_i,
  output vat_pkg::vec16_t             quo_o,
  output logic [SIDE_W-1:0]           side_o
);

  localparam int W = vat_pkg::NUM_W + 2;
  localparam int N = vat_pkg::DIV_STEPS;

  logic [2:0][W-1:0]              rem_r [N];
  vat_pkg::vec16_t                quo_r [N];
  logic [vat_pkg::ROOT_W-1:0]     den_r [N];
  logic [SIDE_W-1:0]              side_r[N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam int SH = N - 1 - k;
    logic [2:0][W-1:0]          rem_in;
    vat_pkg::vec16_t            quo_in;
    logic [vat_pkg::ROOT_W-1:0] den_in;
    logic [SIDE_W-1:0]          side_in;
    logic [W-1:0]               dsh;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 3; l++) begin
          rem_in[l] = W'(num_i[l]);
        end
      end
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign dsh = W'(den_in) << SH;

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (rem_in[l] >= dsh) begin
            rem_r[k][l] <= rem_in[l] - dsh;
            quo_r[k][l] <= {quo_in[l][14:0], 1'b1};
          end else begin
            rem_r[k][l] <= rem_in[l];
            quo_r[k][l] <= {quo_in[l][14:0], 1'b0};
          end
        end
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign quo_o  = quo_r[N-1];
  assign side_o = side_r[N-1];

endmodule

[sv/vat_dir.sv]
// Direction renormalize: squared length, root, divide, fallback select.
module vat_dir (
  input  logic                        clk,
  input  logic                        en,
  input  logic [15:0]                 thr_i,
  input  vat_pkg::vec16_t             fb_i,
  input  vat_pkg::rvec_t              r_i,
  output vat_pkg::vec16_t             dir_o
);

  localparam int RW = vat_pkg::R_W;

  // squares
  logic [vat_pkg::SQ_W-1:0] sq_r [3];
  vat_pkg::rvec_t           r_a_r;
  logic signed [2*RW-1:0]   sq_full [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_full[i] = (2*RW)'($signed(r_i[i])) * (2*RW)'($signed(r_i[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= sq_full[i][vat_pkg::SQ_W-1:0];
      end
      r_a_r <= r_i;
    end
  end

  // length, threshold test, radicand
  logic [vat_pkg::LEN_W-1:0] len;
  logic [vat_pkg::RAD_W-1:0] rad_r;
  logic [3*RW:0]             side_b_r;

  assign len = vat_pkg::LEN_W'(sq_r[0]) + vat_pkg::LEN_W'(sq_r[1])
             + vat_pkg::LEN_W'(sq_r[2]);

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r    <= vat_pkg::RAD_W'(len) << 20;
      side_b_r <= {(len <= vat_pkg::LEN_W'(thr_i)), r_a_r};
    end
  end

  logic [vat_pkg::ROOT_W-1:0] root;
  logic [3*RW:0]              side_c;

  vat_sqrt #(.SIDE_W(3*RW + 1)) u_sqrt (
    .clk    (clk),
    .en     (en),
    .rad_i  (rad_r),
    .side_i (side_b_r),
    .root_o (root),
    .side_o (side_c)
  );

  // dividend = |r| << 24 plus half the root (round half away from zero)
  vat_pkg::rvec_t                 r_c;
  logic [2:0][vat_pkg::NUM_W-1:0] num_r;
  logic [vat_pkg::ROOT_W-1:0]     den_r;
  logic [3:0]                     side_d_r;
  logic [RW-1:0]                  mag [3];

  assign r_c = side_c[3*RW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = r_c[i][RW-1] ? (RW'(0) - r_c[i]) : r_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= (vat_pkg::NUM_W'(mag[i]) << 24) + vat_pkg::NUM_W'(root >> 1);
      end
      den_r    <= root;
      side_d_r <= {side_c[3*RW], r_c[2][RW-1], r_c[1][RW-1], r_c[0][RW-1]};
    end
  end

  vat_pkg::vec16_t quo;
  logic [3:0]      side_e;

  vat_div #(.SIDE_W(4)) u_div (
    .clk    (clk),
    .en     (en),
    .num_i  (num_r),
    .den_i  (den_r),
    .side_i (side_d_r),
    .quo_o  (quo),
    .side_o (side_e)
  );

  // sign, clamp, fallback
  vat_pkg::vec16_t    dir_r;
  logic signed [16:0] sval [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sval[i] = side_e[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dir_r[i] <= side_e[3] ? fb_i[i] : vat_pkg::sat16(36'(sval[i]));
      end
    end
  end

  assign dir_o = dir_r;

endmodule

[sv/vat_chk.sv]
// Port-level checker for the vertex affine transform, with its bind.
module vat_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_pos_x,
  input logic signed [15:0] out_nrm_x,
  input logic signed [15:0] out_nrm_y,
  input logic signed [15:0] out_tan_x
);

  // a held output transaction stays valid and keeps its pos_x and nrm_x
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_nrm_x))
    else $error("output transaction changed while stalled");

  // input backpressure only from a blocked output register
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output blockage");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // renormalized components nrm_x, nrm_y and tan_x stay within unit range
  a_unit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_nrm_x <= 16'sd16500) && (out_nrm_x >= -16'sd16500)
               && (out_nrm_y <= 16'sd16500) && (out_nrm_y >= -16'sd16500)
               && (out_tan_x <= 16'sd16500) && (out_tan_x >= -16'sd16500))
    else $error("direction component out of unit range");

endmodule

bind vertex_affine_transform vat_chk u_vat_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_pos_x (out_pos_x),
  .out_nrm_x (out_nrm_x),
  .out_nrm_y (out_nrm_y),
  .out_tan_x (out_tan_x)
);

[tb/sv/vertex_affine_transform_tb.sv]
// Testbench for vertex_affine_transform: directed table plus random vertices.
`timescale 1ns / 1ps

module vertex_affine_transform_tb;

  localparam int HALF_PERIOD = 4;
  localparam int N_PHASES    = 9;
  localparam int PHASE_ITEMS = 190;
  localparam int DRAIN_WAIT  = 60;    // covers the full pipeline
  localparam int HOLD_CYCLES = 300;   // long receiver hold, pipeline fills
  localparam int STUCK_LIMIT = 2000;  // cycles with no transaction at all

  // Unused register codes: writes there must be ignored.
  localparam logic [vat_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd4;
  localparam logic [vat_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Field slots of a vertex, same order on the input and result side.
  localparam int F_HAND = 9;
  localparam int F_TEXU = 10;
  localparam int F_TEXV = 11;

  typedef logic [11:0][15:0] vtx_t;

  typedef struct {
    vtx_t stim;
    bit   known;   // want is typed in, no predictor needed
    vtx_t want;
  } vtx_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [vat_pkg::IDX_W-1:0] cfg_index = '0;
  logic [vat_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic signed [15:0] in_nrm_x = '0, in_nrm_y = '0, in_nrm_z = '0;
  logic signed [15:0] in_tan_x = '0, in_tan_y = '0, in_tan_z = '0;
  logic in_tan_neg = 1'b0;
  logic [15:0] in_tex_u = '0, in_tex_v = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_nrm_x, out_nrm_y, out_nrm_z;
  logic signed [15:0] out_tan_x, out_tan_y, out_tan_z;
  logic out_handed_neg;
  logic [15:0] out_tex_u, out_tex_v;

  vertex_affine_transform u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .in_nrm_x(in_nrm_x), .in_nrm_y(in_nrm_y), .in_nrm_z(in_nrm_z),
    .in_tan_x(in_tan_x), .in_tan_y(in_tan_y), .in_tan_z(in_tan_z),
    .in_tan_neg(in_tan_neg), .in_tex_u(in_tex_u), .in_tex_v(in_tex_v),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_nrm_x(out_nrm_x), .out_nrm_y(out_nrm_y), .out_nrm_z(out_nrm_z),
    .out_tan_x(out_tan_x), .out_tan_y(out_tan_y), .out_tan_z(out_tan_z),
    .out_handed_neg(out_handed_neg), .out_tex_u(out_tex_u), .out_tex_v(out_tex_v)
  );

  always #HALF_PERIOD clk = ~clk;

  // Local copy of the register file, updated on every write we issue.
  logic [vat_pkg::CFG_W-1:0] mat_row [3];
  logic [15:0]               len_floor;

  vtx_t     expected_q [$];
  vtx_row_t dir_tab [$];
  int   n_mismatch = 0;
  bit   quiet_phase = 0;   // last part of the run: no idling anywhere
  bit   hold_now = 0;      // receiver long hold requested

  string fld_name [12] = '{"pos_x", "pos_y", "pos_z", "nrm_x", "nrm_y", "nrm_z",
                           "tan_x", "tan_y", "tan_z", "handed_neg", "tex_u", "tex_v"};

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic longint coef(input logic [vat_pkg::CFG_W-1:0] row, input int k);
    logic signed [15:0] f;
    f = row[16*k +: 16];
    return longint'(f);
  endfunction

  function automatic logic [15:0] clamp16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Linear part, round to Q.14, then scale to unit length or fall back.
  function automatic logic [2:0][15:0] unit_dir(input logic [2:0][15:0] d,
                                                input logic [2:0][15:0] fb);
    longint r [3];
    longint acc;
    longint unsigned len, s, mag, q;
    logic [2:0][15:0] o;
    len = 0;
    for (int i = 0; i < 3; i++) begin
      acc = longint'($signed(d[0])) * coef(mat_row[i], 0)
          + longint'($signed(d[1])) * coef(mat_row[i], 1)
          + longint'($signed(d[2])) * coef(mat_row[i], 2);
      r[i] = (acc + 2048) >>> 12;
      len += longint'(r[i] * r[i]);
    end
    if (len <= {48'd0, len_floor}) return fb;
    s = root_floor(len << 20);
    for (int i = 0; i < 3; i++) begin
      mag = longint'(r[i] < 0 ? -r[i] : r[i]) << 24;
      q = (mag + (s >> 1)) / s;
      o[i] = clamp16(r[i] < 0 ? -longint'(q) : longint'(q));
    end
    return o;
  endfunction

  function automatic vtx_t transform_vertex(input vtx_t v);
    vtx_t o;
    longint acc;
    for (int i = 0; i < 3; i++) begin
      acc = longint'($signed(v[0])) * coef(mat_row[i], 0)
          + longint'($signed(v[1])) * coef(mat_row[i], 1)
          + longint'($signed(v[2])) * coef(mat_row[i], 2)
          + coef(mat_row[i], 3) * 4096;
      o[i] = clamp16((acc + 2048) >>> 12);
    end
    o[5:3] = unit_dir(v[5:3], {vat_pkg::Q14_ZERO, vat_pkg::Q14_ONE, vat_pkg::Q14_ZERO});
    o[8:6] = unit_dir(v[8:6], {vat_pkg::Q14_ZERO, vat_pkg::Q14_ZERO, vat_pkg::Q14_ONE});
    o[F_HAND] = {15'd0, v[F_HAND][0]};
    o[F_TEXU] = v[F_TEXU];
    o[F_TEXV] = v[F_TEXV];
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic vtx_t mk(input int px, py, pz, nx, ny, nz, tx, ty, tz,
                              input int hand, tu, tv);
    vtx_t v;
    v[0] = px[15:0]; v[1] = py[15:0]; v[2] = pz[15:0];
    v[3] = nx[15:0]; v[4] = ny[15:0]; v[5] = nz[15:0];
    v[6] = tx[15:0]; v[7] = ty[15:0]; v[8] = tz[15:0];
    v[F_HAND] = {15'd0, hand[0]};
    v[F_TEXU] = tu[15:0];
    v[F_TEXV] = tv[15:0];
    return v;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input vtx_t stim, input bit known, input vtx_t want);
    vtx_row_t e;
    e.stim  = stim;
    e.known = known;
    e.want  = want;
    dir_tab = {dir_tab, e};
  endfunction

  function automatic logic [15:0] rand_dir_comp(input int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 16)) - 8);           // near threshold
      2: return 16'($signed($urandom_range(0, 32768)) - 16384);    // unit range
      default: return 16'($signed($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  function automatic vtx_t rand_vertex();
    vtx_t v;
    int nm, tm;
    nm = $urandom_range(0, 3);
    tm = $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      v[i]     = 16'($urandom);
      v[3 + i] = rand_dir_comp(nm);
      v[6 + i] = rand_dir_comp(tm);
    end
    v[F_HAND] = {15'd0, 1'($urandom)};
    v[F_TEXU] = 16'($urandom);
    v[F_TEXV] = 16'($urandom);
    return v;
  endfunction

  // Plausible matrix row: Q3.12 entries within +-1.0, any translation.
  function automatic logic [vat_pkg::CFG_W-1:0] sane_row();
    logic [vat_pkg::CFG_W-1:0] r;
    for (int k = 0; k < 3; k++) r[16*k +: 16] = 16'($signed($urandom_range(0, 8192)) - 4096);
    r[63:48] = 16'($urandom);
    return r;
  endfunction

  // Drives one register write; caller drops cfg_we after the last one.
  task automatic reg_write(input logic [vat_pkg::IDX_W-1:0] idx,
                           input logic [vat_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      vat_pkg::REG_ROW_X:   mat_row[0] = val;
      vat_pkg::REG_ROW_Y:   mat_row[1] = val;
      vat_pkg::REG_ROW_Z:   mat_row[2] = val;
      vat_pkg::REG_MIN_LEN: len_floor  = val[15:0];
      default: ;
    endcase
  endtask

  // Offers one vertex until accepted; queues its expected transform.
  task automatic send_vertex(input vtx_t v, input bit known, input vtx_t want);
    if (!quiet_phase && !hold_now && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_pos_x   <= v[0]; in_pos_y <= v[1]; in_pos_z <= v[2];
    in_nrm_x   <= v[3]; in_nrm_y <= v[4]; in_nrm_z <= v[5];
    in_tan_x   <= v[6]; in_tan_y <= v[7]; in_tan_z <= v[8];
    in_tan_neg <= v[F_HAND][0];
    in_tex_u   <= v[F_TEXU];
    in_tex_v   <= v[F_TEXV];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_q = {expected_q, (known ? want : transform_vertex(v))};
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, one long hold on request, none at the end.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_now) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_now = 0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each transaction on the result channel with the oldest expectation.
  always @(posedge clk) begin
    vtx_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_tex_v, out_tex_u, {15'd0, out_handed_neg},
             out_tan_z, out_tan_y, out_tan_x, out_nrm_z, out_nrm_y, out_nrm_x,
             out_pos_z, out_pos_y, out_pos_x};
      if (expected_q.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("ERROR: unexpected result transaction");
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 12; i++) begin
          if (got[i] !== want[i]) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("ERROR: %s expected %h got %h", fld_name[i], want[i], got[i]);
          end
        end
      end
    end
  end

  // Watchdog: no transaction on either channel for too long.
  int stuck_cnt = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cnt <= 0;
    end else if (stuck_cnt >= STUCK_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cnt <= stuck_cnt + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    vtx_t       none;
    logic [vat_pkg::CFG_W-1:0] rv [3];
    logic [15:0] fl;

    none = '0;
    mat_row[0] = vat_pkg::ROW_X_RST;
    mat_row[1] = vat_pkg::ROW_Y_RST;
    mat_row[2] = vat_pkg::ROW_Z_RST;
    len_floor  = vat_pkg::MIN_LEN_RST;

    // Identity transform after reset: position passes, unit axes stay unit.
    add_row(mk(32767, -32768, 0, 0, 16384, 0, 16384, 0, 0, 0, 0, 0), 1,
            mk(32767, -32768, 0, 0, 16384, 0, 16384, 0, 0, 0, 0, 0));
    // zero-length directions fall back to +Y and +X
    add_row(mk(-32768, 32767, -1, 0, 0, 0, 0, 0, 0, 1, 65535, 65535), 1,
            mk(-32768, 32767, -1, 0, 16384, 0, 16384, 0, 0, 1, 65535, 65535));
    // full-scale components renormalize to exactly one
    add_row(mk(0, 0, 0, -32768, 0, 0, 0, 0, 32767, 0, 'h1234, 'hABCD), 1,
            mk(0, 0, 0, -16384, 0, 0, 0, 0, 16384, 0, 'h1234, 'hABCD));
    // below threshold
    add_row(mk(1, 2, 3, 5, 0, 0, 0, -5, 0, 1, 'h5555, 'hAAAA), 1,
            mk(1, 2, 3, 0, 16384, 0, 16384, 0, 0, 1, 'h5555, 'hAAAA));
    // exactly at threshold still falls back
    add_row(mk(4, 5, 6, 3, 3, 3, 1, 1, 5, 0, 'hAAAA, 'h5555), 1,
            mk(4, 5, 6, 0, 16384, 0, 16384, 0, 0, 0, 'hAAAA, 'h5555));
    // just above threshold
    add_row(mk(7, 8, 9, 0, 0, 6, -6, 0, 0, 1, 1, 2), 1,
            mk(7, 8, 9, 0, 0, 16384, -16384, 0, 0, 1, 1, 2));
    // oblique and saturating cases go through the predictor
    add_row(mk(1, -1, 32767, 32767, 32767, 32767, -32768, -32768, -32768,
               0, 'h8000, 'h7FFF), 0, none);
    add_row(mk(-1, -1, -1, 1, -1, 1, 3, -4, 0, 1, 'h7FFF, 'h8000), 0, none);
    add_row(mk(256, -256, 128, 11585, 11585, 0, 0, -9459, 9459, 0, 3, 4), 0, none);
    add_row(mk(32767, 32767, 32767, -1, -2, -3, 100, 200, -300, 1, 9, 9), 0, none);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) send_vertex(dir_tab[i].stim, dir_tab[i].known, dir_tab[i].want);
    wait_drained();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin  // fully random register contents
          for (int k = 0; k < 3; k++) rv[k] = {$urandom, $urandom};
          fl = 16'($urandom);
        end
        1: begin  // all zero: translation only, every direction falls back
          for (int k = 0; k < 3; k++) rv[k] = '0;
          fl = 16'd0;
        end
        2: begin  // every field -1, largest threshold
          for (int k = 0; k < 3; k++) rv[k] = '1;
          fl = 16'hFFFF;
        end
        3: begin  // largest positive entries, zero threshold
          for (int k = 0; k < 3; k++) rv[k] = {4{16'h7FFF}};
          fl = 16'd0;
        end
        4: begin  // most negative entries
          for (int k = 0; k < 3; k++) rv[k] = {4{16'h8000}};
          fl = 16'd1;
        end
        default: begin
          for (int k = 0; k < 3; k++) rv[k] = sane_row();
          fl = 16'($urandom_range(0, 64));
        end
      endcase
      reg_write(vat_pkg::REG_ROW_X, rv[0]);
      reg_write(vat_pkg::REG_ROW_Y, rv[1]);
      reg_write(vat_pkg::REG_ROW_Z, rv[2]);
      // upper data bits set on the threshold write; they must be dropped
      reg_write(vat_pkg::REG_MIN_LEN, {16'($urandom), 16'($urandom), 16'($urandom), fl});
      if (ph == 5) begin
        // writes to unused codes must not land anywhere
        reg_write(REG_SPARE_LO, '1);
        reg_write(REG_SPARE_HI, '0);
      end
      cfg_we <= 1'b0;
      @(posedge clk);

      quiet_phase = (ph == N_PHASES - 1);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // one long hold early on with the sender pushing at full rate
        if (ph == 6 && n == 20) hold_now = 1;
        send_vertex(rand_vertex(), 0, none);
      end
      wait_drained();
    end

    if (n_mismatch == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/vat_pkg.sv
sv/vat_sqrt.sv
sv/vat_div.sv
sv/vat_dir.sv
sv/vertex_affine_transform.sv
sv/vat_chk.sv
tb/sv/vertex_affine_transform_tb.sv
